[sv/mtfc_pkg.sv]
// Shared constants and controller-to-datapath types for the move-to-front codec.
`timescale 1ns / 1ps

package mtfc_pkg;

    localparam int SYM_W         = 8;
    localparam int ALPHABET_SIZE = 256;
    localparam int ADDR_W        = $clog2(ALPHABET_SIZE);
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 1'd1;

    typedef struct packed {
        logic start;
        logic scan;
        logic final_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic oor;
        logic match;
    } t_dp_sts;

endpackage

[sv/mtfc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mtfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mtfc_datapath.sv]
// Datapath of the move-to-front codec: symbol table, scan pipeline and result register.
`timescale 1ns / 1ps

module mtfc_datapath import mtfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data,
    input  logic [SYM_W-1:0]     i_sym,
    input  logic                 i_block_start,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [SYM_W-1:0]     o_out_data
);

    logic                     r_direction;
    logic                     r_variant;
    logic                     r_prevnz;
    logic [ALPHABET_SIZE-1:0] r_valid;
    logic [SYM_W-1:0]         r_x;
    logic [ADDR_W-1:0]        r_addr;
    logic [ADDR_W-1:0]        r_kd;
    logic                     r_dv;
    logic                     r_vld_d;
    logic [SYM_W-1:0]         r_carry;
    logic [ADDR_W-1:0]        r_pos;
    logic [SYM_W-1:0]         r_sym;
    logic [SYM_W-1:0]         r_result;
    logic [SYM_W-1:0]         r_out_data;

    logic [SYM_W-1:0]  ram_q;
    logic [SYM_W-1:0]  entry;
    logic              match_cond;
    logic              scan_hit;
    logic              scan_we;
    logic              fin_we;
    logic [ADDR_W-1:0] fin_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SYM_W-1:0]  ram_wdata;

    // An entry not written since the last block start holds its own index.
    assign entry      = r_vld_d ? ram_q : SYM_W'(r_kd);
    assign match_cond = r_direction ? (SYM_W'(r_kd) == r_x) : (entry == r_x);
    assign scan_hit   = i_cmd.scan && r_dv && match_cond;

    assign scan_we = i_cmd.scan && r_dv && (r_kd != '0)
                     && !(r_variant && (r_kd == ADDR_W'(1)) && match_cond && !r_prevnz);
    assign fin_we  = i_cmd.final_wr && (r_pos != '0)
                     && (!r_variant || (r_pos != ADDR_W'(1)) || r_prevnz);
    assign fin_addr = (!r_variant || (r_pos == ADDR_W'(1))) ? '0 : ADDR_W'(1);

    assign ram_we    = scan_we || fin_we;
    assign ram_waddr = i_cmd.final_wr ? fin_addr : r_kd;
    assign ram_wdata = i_cmd.final_wr ? r_sym : r_carry;

    mtfc_ram #(
        .WIDTH (SYM_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_variant   <= 1'b0;
            r_prevnz    <= 1'b1;
            r_valid     <= '0;
            r_dv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DIRECTION: r_direction <= i_cfg_data;
                    REG_VARIANT:   r_variant   <= i_cfg_data;
                    default:       r_direction <= r_direction;
                endcase
            end
            if (i_cmd.start) begin
                r_dv <= 1'b0;
                if (i_block_start) begin
                    r_valid  <= '0;
                    r_prevnz <= 1'b1;
                end
            end else if (i_cmd.scan) begin
                r_dv <= 1'b1;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (i_cmd.final_wr) begin
                r_prevnz <= (r_pos != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x      <= i_sym;
            r_addr   <= '0;
            r_result <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (i_cmd.scan) begin
            r_kd    <= r_addr;
            r_vld_d <= r_valid[r_addr];
        end
        if (i_cmd.scan && r_dv) begin
            r_carry <= entry;
        end
        if (scan_hit) begin
            r_pos    <= r_kd;
            r_sym    <= r_direction ? entry : r_x;
            r_result <= r_direction ? entry : SYM_W'(r_kd);
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_result;
        end
    end

    assign o_sts.oor   = {1'b0, i_sym} >= (SYM_W + 1)'(ALPHABET_SIZE);
    assign o_sts.match = scan_hit;
    assign o_out_data  = r_out_data;

endmodule

[sv/mtfc_ctrl.sv]
// Controller state machine of the move-to-front codec.
`timescale 1ns / 1ps

module mtfc_ctrl import mtfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.final_wr = (r_state == S_FINAL);
        o_cmd.load_out = (r_state == S_EMIT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= i_sts.oor ? S_EMIT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_sts.match) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/move_to_front_codec.sv]
// Top level of the byte-wide move-to-front encoder and decoder (MTF-0 and MTF-2).
// An item is accepted, its table position is found by the scan, the table is updated and its result word is emitted.
// The next word can be accepted once the result is registered, while that result may still wait.
// The table sits in a single-port-read RAM and is scanned one entry per cycle from position 0.
// An out-of-range word would skip the scan and return 0; with 8-bit words and 256 entries none can occur.
// Reset restores the identity table at once through per-entry valid flags; no clearing pass.
`timescale 1ns / 1ps

module move_to_front_codec import mtfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] symbol_in
    input  logic                 s_axis_tuser,   // [0] block_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata    // [7:0] symbol_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mtfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mtfc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_sym         (s_axis_tdata),
        .i_block_start (s_axis_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_data    (m_axis_tdata)
    );

endmodule

[bench/tb_move_to_front_codec.sv]
// Self-checking testbench for the move-to-front codec: directed and random words in every mode.
`timescale 1ns / 1ps

class mtf_tracker;
    logic [7:0] sym_order [256];
    bit         prev_nonzero;
    bit         decode_mode;
    bit         mtf2_mode;
    logic [7:0] expected_symbols [$];
    int         errors;

    function new();
        load_identity();
        decode_mode = 1'b0;
        mtf2_mode   = 1'b0;
        errors      = 0;
    endfunction

    function void load_identity();
        for (int k = 0; k < 256; k++) begin
            sym_order[k] = k[7:0];
        end
        prev_nonzero = 1'b1;
    endfunction

    function void set_regs(bit decode, bit mtf2);
        decode_mode = decode;
        mtf2_mode   = mtf2;
    endfunction

    function int pending();
        return expected_symbols.size();
    endfunction

    // Shifts entries dest..pos-1 up by one and places sym at dest.
    function void move_forward(int pos, int dest, logic [7:0] sym);
        for (int k = pos; k > dest; k--) begin
            sym_order[k] = sym_order[k-1];
        end
        sym_order[dest] = sym;
    endfunction

    function void note_word(logic [7:0] sym_in, bit block_start);
        int         pos;
        logic [7:0] sym;
        pos = 0;
        if (block_start) begin
            load_identity();
        end
        if (!decode_mode) begin
            for (int k = 0; k < 256; k++) begin
                if (sym_order[k] == sym_in) begin
                    pos = k;
                    break;
                end
            end
            sym = sym_in;
            expected_symbols.push_back(pos[7:0]);
        end else begin
            pos = int'(sym_in);
            sym = sym_order[pos];
            expected_symbols.push_back(sym);
        end
        if (!mtf2_mode) begin
            if (pos > 0) begin
                move_forward(pos, 0, sym);
            end
        end else if (pos == 1) begin
            if (prev_nonzero) begin
                sym_order[1] = sym_order[0];
                sym_order[0] = sym;
            end
        end else if (pos > 1) begin
            move_forward(pos, 1, sym);
        end
        prev_nonzero = (pos != 0);
    endfunction

    function void check_word(logic [7:0] actual);
        logic [7:0] want;
        if (expected_symbols.size() == 0) begin
            $display("%0t: unexpected output word, actual %0d", $time, actual);
            errors++;
        end else begin
            want = expected_symbols.pop_front();
            if (actual !== want) begin
                $display("%0t: symbol_out mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                errors++;
            end
        end
    endfunction
endclass

module tb_move_to_front_codec;
    import mtfc_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = REG_DIRECTION;
    logic                 i_cfg_data    = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'd0;   // [7:0] symbol_in
    logic                 s_axis_tuser  = 1'b0;   // [0] block_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;           // [7:0] symbol_out

    mtf_tracker tracker;
    int         tx_max_gap   = 18;
    int         rx_max_stall = 18;

    move_to_front_codec DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_word(input logic [7:0] sym, input bit block_start);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= block_start;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_word(sym, block_start);
    endtask

    task automatic apply_config(input bit decode, input bit mtf2);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_DIRECTION;
        i_cfg_data <= decode;
        @(posedge i_clk);
        i_cfg_idx  <= REG_VARIANT;
        i_cfg_data <= mtf2;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_regs(decode, mtf2);
    endtask

    // Encoding draws mostly from a small pool so recent symbols sit near the front.
    task automatic run_phase(input int count);
        logic [7:0] pool [12];
        logic [7:0] sym;
        bit         block_start;
        for (int k = 0; k < 12; k++) begin
            pool[k] = 8'($urandom_range(0, 255));
        end
        for (int n = 0; n < count; n++) begin
            block_start = ($urandom_range(0, 39) == 0);
            if (tracker.decode_mode) begin
                sym = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 15));
            end else begin
                sym = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                  : pool[$urandom_range(0, 11)];
            end
            send_word(sym, block_start);
        end
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_word(m_axis_tdata);
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("move_to_front_codec regression: fail");
        $finish;
    end

    initial begin : stimulus
        bit decode;
        bit mtf2;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers: encode with MTF-0.
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd128, 1'b1);
        send_word(8'd128, 1'b0);

        // MTF-2: position 1 after a zero position must not swap, after a nonzero one it must.
        apply_config(1'b0, 1'b1);
        send_word(8'd0, 1'b1);
        send_word(8'd1, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd200, 1'b0);
        send_word(8'd255, 1'b0);

        apply_config(1'b1, 1'b0);
        send_word(8'd255, 1'b1);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd1, 1'b0);

        apply_config(1'b1, 1'b1);
        send_word(8'd0, 1'b1);
        send_word(8'd1, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd2, 1'b0);

        // Later phases usually continue the running table across a register change.
        for (int p = 0; p < 10; p++) begin
            if (p < 4) begin
                decode = p[1];
                mtf2   = p[0];
            end else begin
                decode = 1'($urandom_range(0, 1));
                mtf2   = 1'($urandom_range(0, 1));
            end
            tx_max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 18;
            rx_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 18;
            apply_config(decode, mtf2);
            run_phase(80);
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("move_to_front_codec regression: pass");
        end else begin
            $display("move_to_front_codec regression: fail");
        end
        $finish;
    end
endmodule
